// ----- rtl/archive_directory_parser_unit_assert.svh -----
// Assertion macros shared by the archive directory parser modules.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ARCHIVE_DIRECTORY_PARSER_UNIT_ASSERT_SVH
`define ARCHIVE_DIRECTORY_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/adp_pkg.sv -----
// ----------------------------------------------------------------------------
// adp_pkg
// Types, constants and helper functions of the archive directory parser.
// ----------------------------------------------------------------------------
`default_nettype none

package adp_pkg;

  localparam int POSITION_BITS = 48;

  localparam int NAME_LEN_W  = 12;
  localparam int SIZE_W      = 44;
  localparam int OFFSET_W    = 48;
  localparam int FCOUNT_W    = 12;
  localparam int PROP_W      = 8;
  localparam int MAX_RESULTS = 3;

  localparam int SIG_LEN     = 5;
  localparam int NLEN_DIGITS = 3;
  localparam int SIZE_DIGITS = 11;
  localparam int PROP_CHARS  = 8;
  localparam int CRC_CHARS   = 10;
  // A final byte below this offset means the archive is too short to hold anything.
  localparam int MIN_ARCHIVE = 7;

  localparam logic [7:0] CH_PAD  = 8'h26;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [7:0] {
    PH_SIG   = 8'b0000_0001,
    PH_NLEN  = 8'b0000_0010,
    PH_NAME  = 8'b0000_0100,
    PH_SIZE  = 8'b0000_1000,
    PH_PROP  = 8'b0001_0000,
    PH_CRC   = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_DRAIN = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    K_NAME   = 3'd0,
    K_CRC    = 3'd1,
    K_REC    = 3'd2,
    K_DONE   = 3'd3,
    K_EMPTY  = 3'd4,
    K_BADSIG = 3'd5,
    K_BADHEX = 3'd6,
    K_TRUNC  = 3'd7
  } kind_t;

  // Results of one input byte. Character results only ever sit in the first slot.
  typedef struct packed {
    logic [1:0]            count;
    kind_t                 kind0;
    kind_t                 kind1;
    kind_t                 kind2;
    logic [7:0]            char_value;
    logic [NAME_LEN_W-1:0] name_length;
    logic [SIZE_W-1:0]     entry_size;
    logic [PROP_W-1:0]     property_bits;
    logic [OFFSET_W-1:0]   data_offset;
  } bundle_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h25;
      3'd1:    b = 8'h42;
      3'd2:    b = 8'h41;
      3'd3:    b = 8'h54;
      3'd4:    b = 8'h25;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Value of a hex character in either case; 16 flags a character that is not hex.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 5'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 5'(c - 8'h57);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/adp_in_if.sv -----
// ----------------------------------------------------------------------------
// adp_in_if
// Archive byte channel: one byte and its end-of-archive flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface adp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/adp_out_if.sv -----
// ----------------------------------------------------------------------------
// adp_out_if
// Parser result channel: one character, record or status per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface adp_out_if import adp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [2:0]            kind;
  logic [7:0]            char_value;
  logic [NAME_LEN_W-1:0] name_length;
  logic [SIZE_W-1:0]     entry_size;
  logic [PROP_W-1:0]     property_bits;
  logic [OFFSET_W-1:0]   data_offset;
  logic                  run_end;

  modport source (output valid, output kind, output char_value, output name_length,
                  output entry_size, output property_bits, output data_offset,
                  output run_end, input ready);
  modport sink   (input valid, input kind, input char_value, input name_length,
                  input entry_size, input property_bits, input data_offset,
                  input run_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/adp_parse_core.sv -----
// ----------------------------------------------------------------------------
// adp_parse_core
// Parser state registers and the per-byte decode that forms a result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "archive_directory_parser_unit_assert.svh"

module adp_parse_core import adp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output bundle_t    bundle
);

  phase_t                   phase_r, phase_nxt;
  logic [FCOUNT_W-1:0]      fc_r, fc_nxt;
  logic [SIZE_W-1:0]        acc_r, acc_nxt;
  logic [NAME_LEN_W-1:0]    hn_r, hn_nxt;
  logic [SIZE_W-1:0]        hs_r, hs_nxt;
  logic [PROP_W-1:0]        hp_r, hp_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [SIZE_W-1:0]        rem_r, rem_nxt;

  logic [FCOUNT_W:0]        fc_inc;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [4:0]               hv;
  logic                     is_pad;
  logic                     entry_done;
  logic                     failed;
  logic                     reset_all;
  logic [1:0]               n;
  kind_t                    slot_kind [MAX_RESULTS];

  assign fc_inc  = {1'b0, fc_r} + (FCOUNT_W+1)'(1);
  assign pos_inc = pos_r + POSITION_BITS'(1);
  assign hv      = hex_value(data_byte);
  assign is_pad  = (data_byte == CH_PAD);

  always_comb begin
    phase_nxt  = phase_r;
    fc_nxt     = fc_r;
    acc_nxt    = acc_r;
    hn_nxt     = hn_r;
    hs_nxt     = hs_r;
    hp_nxt     = hp_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_inc;
    entry_done = 1'b0;
    failed     = 1'b0;
    reset_all  = 1'b0;
    n          = 2'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      slot_kind[i] = K_DONE;
    end
    bundle               = '0;

    if (phase_r == PH_DRAIN) begin
      reset_all = final_byte;
    end else if (final_byte && (pos_r < POSITION_BITS'(MIN_ARCHIVE))) begin
      slot_kind[n] = K_EMPTY;
      n            = n + 2'd1;
      reset_all    = 1'b1;
    end else begin
      case (phase_r)
        PH_SIG: begin
          if ((fc_r > FCOUNT_W'(SIG_LEN - 1)) || (data_byte != sig_byte(fc_r[2:0]))) begin
            slot_kind[n] = K_BADSIG;
            n            = n + 2'd1;
            failed       = 1'b1;
          end else begin
            fc_nxt = fc_inc[FCOUNT_W-1:0];
            if (fc_inc == (FCOUNT_W+1)'(SIG_LEN)) begin
              phase_nxt = PH_NLEN;
              fc_nxt    = '0;
              acc_nxt   = '0;
            end
          end
        end
        PH_NLEN, PH_SIZE: begin
          if (!is_pad && hv[4]) begin
            slot_kind[n] = K_BADHEX;
            n            = n + 2'd1;
            failed       = 1'b1;
          end else begin
            if (!is_pad) begin
              acc_nxt = {acc_r[SIZE_W-5:0], hv[3:0]};
            end
            fc_nxt = fc_inc[FCOUNT_W-1:0];
            if ((phase_r == PH_NLEN) && (fc_inc >= (FCOUNT_W+1)'(NLEN_DIGITS))) begin
              hn_nxt    = acc_nxt[NAME_LEN_W-1:0];
              phase_nxt = (hn_nxt == '0) ? PH_SIZE : PH_NAME;
              fc_nxt    = '0;
              acc_nxt   = '0;
            end else if ((phase_r == PH_SIZE) &&
                         (fc_inc >= (FCOUNT_W+1)'(SIZE_DIGITS))) begin
              hs_nxt    = acc_nxt;
              hp_nxt    = '0;
              phase_nxt = PH_PROP;
              fc_nxt    = '0;
              acc_nxt   = '0;
            end
          end
        end
        PH_NAME: begin
          slot_kind[n]      = K_NAME;
          n                 = n + 2'd1;
          bundle.char_value = data_byte;
          fc_nxt            = fc_inc[FCOUNT_W-1:0];
          if (fc_inc >= {1'b0, hn_r}) begin
            phase_nxt = PH_SIZE;
            fc_nxt    = '0;
            acc_nxt   = '0;
          end
        end
        PH_PROP: begin
          if (data_byte != CH_ZERO) begin
            hp_nxt = hp_r | (PROP_W'(1) << fc_r[2:0]);
          end
          fc_nxt = fc_inc[FCOUNT_W-1:0];
          if (fc_inc >= (FCOUNT_W+1)'(PROP_CHARS)) begin
            phase_nxt = PH_CRC;
            fc_nxt    = '0;
            acc_nxt   = '0;
          end
        end
        PH_CRC: begin
          if (!is_pad) begin
            slot_kind[n]      = K_CRC;
            n                 = n + 2'd1;
            bundle.char_value = data_byte;
          end
          fc_nxt = fc_inc[FCOUNT_W-1:0];
          if (fc_inc >= (FCOUNT_W+1)'(CRC_CHARS)) begin
            slot_kind[n]         = K_REC;
            n                    = n + 2'd1;
            bundle.name_length   = hn_r;
            bundle.entry_size    = hs_r;
            bundle.property_bits = hp_r;
            bundle.data_offset   = OFFSET_W'(pos_inc);
            if (hs_r == '0) begin
              entry_done = 1'b1;
            end else begin
              rem_nxt   = hs_r;
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          rem_nxt    = rem_r - SIZE_W'(1);
          entry_done = (rem_nxt == '0);
        end
        default: begin
        end
      endcase

      if (failed) begin
        if (final_byte) begin
          reset_all = 1'b1;
        end else begin
          phase_nxt = PH_DRAIN;
        end
      end else if (final_byte) begin
        // Reaching the end inside entry data counts as a complete archive.
        slot_kind[n] = (entry_done || (phase_nxt == PH_DATA)) ? K_DONE : K_TRUNC;
        n            = n + 2'd1;
        reset_all    = 1'b1;
      end else if (entry_done) begin
        phase_nxt = PH_NLEN;
        fc_nxt    = '0;
        acc_nxt   = '0;
      end
    end

    if (reset_all) begin
      phase_nxt = PH_SIG;
      fc_nxt    = '0;
      acc_nxt   = '0;
      hn_nxt    = '0;
      hs_nxt    = '0;
      hp_nxt    = '0;
      pos_nxt   = '0;
      rem_nxt   = '0;
    end

    bundle.count = n;
    bundle.kind0 = slot_kind[0];
    bundle.kind1 = slot_kind[1];
    bundle.kind2 = slot_kind[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      fc_r    <= '0;
      acc_r   <= '0;
      hn_r    <= '0;
      hs_r    <= '0;
      hp_r    <= '0;
      pos_r   <= '0;
      rem_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      acc_r   <= acc_nxt;
      hn_r    <= hn_nxt;
      hs_r    <= hs_nxt;
      hp_r    <= hp_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
    end
  end

  `ADP_ASSERT_NEXT(a_final_rewinds, in_fire && final_byte, pos_r == '0 && phase_r == PH_SIG, "final byte did not return the parser to its start")
  `ADP_ASSERT_IMP(a_drain_silent, in_fire && phase_r == PH_DRAIN, bundle.count == 2'd0, "bytes after an error produced results")

endmodule

`default_nettype wire

// ----- rtl/adp_result_queue.sv -----
// ----------------------------------------------------------------------------
// adp_result_queue
// Holds the result bundle of one byte and hands its results out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "archive_directory_parser_unit_assert.svh"

module adp_result_queue import adp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  bundle_t     bundle,
  output logic        in_ready,
  adp_out_if.source   out_stream
);

  logic    valid_r;
  logic    [1:0] idx_r;
  bundle_t bundle_r;
  logic    last;
  kind_t   cur_kind;

  assign last     = (idx_r == (bundle_r.count - 2'd1));
  // A new bundle may land in the same cycle the last result of the old one leaves.
  assign in_ready = !valid_r || (out_stream.ready && last);

  always_comb begin
    case (idx_r)
      2'd0:    cur_kind = bundle_r.kind0;
      2'd1:    cur_kind = bundle_r.kind1;
      default: cur_kind = bundle_r.kind2;
    endcase
  end

  assign out_stream.valid         = valid_r;
  assign out_stream.kind          = cur_kind;
  assign out_stream.char_value    = (cur_kind == K_NAME || cur_kind == K_CRC) ?
                                    bundle_r.char_value : '0;
  assign out_stream.name_length   = (cur_kind == K_REC) ? bundle_r.name_length : '0;
  assign out_stream.entry_size    = (cur_kind == K_REC) ? bundle_r.entry_size : '0;
  assign out_stream.property_bits = (cur_kind == K_REC) ? bundle_r.property_bits : '0;
  assign out_stream.data_offset   = (cur_kind == K_REC) ? bundle_r.data_offset : '0;
  assign out_stream.run_end       = last;

  always_ff @(posedge clk) begin
    if (load) begin
      bundle_r <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_stream.ready) begin
      if (last) begin
        valid_r <= 1'b0;
        idx_r   <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  `ADP_ASSERT_IMP(a_idx_in_range, valid_r, idx_r < bundle_r.count, "result index ran past the bundle")
  `ADP_ASSERT_NEXT(a_stall_holds, valid_r && !out_stream.ready, valid_r && $stable(idx_r), "stalled result moved")
  `ADP_ASSERT_IMP(a_load_when_free, load && valid_r, out_stream.ready && last, "bundle overwritten before it was drained")

endmodule

`default_nettype wire

// ----- rtl/archive_directory_parser_unit.sv -----
// ----------------------------------------------------------------------------
// archive_directory_parser_unit
// Archive directory parser: signature check, entry header walk, data skip.
// ----------------------------------------------------------------------------
// The parser takes one archive byte per cycle. Each accepted byte is decoded in
// the same cycle against the parser state and its results (none, or up to three)
// are stored in a result buffer; they appear on the output in the next cycle,
// one per cycle. A byte that causes at most one result lets the next byte in on
// the following cycle, so headers, names and skipped data run at one byte per
// cycle. A byte that causes two or three results (the last CRC character with
// its entry record, or a final byte with another result) holds the input as the
// single output port drains the buffer one result at a time. Output stalls hold
// the input only once the buffered results of the previous byte are not taken.
`default_nettype none

module archive_directory_parser_unit import adp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  adp_in_if.sink    in_stream,
  adp_out_if.source out_stream
);

  logic    in_fire;
  logic    ready_w;
  bundle_t bundle;

  assign in_stream.ready = ready_w;
  assign in_fire         = in_stream.valid && ready_w;

  adp_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_stream.data_byte),
    .final_byte (in_stream.final_byte),
    .bundle     (bundle)
  );

  adp_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire && (bundle.count != 2'd0)),
    .bundle     (bundle),
    .in_ready   (ready_w),
    .out_stream (out_stream)
  );

endmodule

`default_nettype wire

// ----- tb/parse_result_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parse_result_check
// Watches both channels of the archive directory parser. Every accepted
// archive byte is run through a behavioral parser that queues the results it
// causes, and every accepted result is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module parse_result_check import adp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  adp_in_if           byte_bus,
  adp_out_if          result_bus,
  output int unsigned fail_count,
  output int unsigned backlog
);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_value;
    logic [11:0] name_length;
    logic [43:0] entry_size;
    logic [7:0]  property_bits;
    logic [47:0] data_offset;
    logic        run_end;
  } parse_result_t;

  localparam logic [7:0] MAGIC [5] = '{8'h25, 8'h42, 8'h41, 8'h54, 8'h25};

  parse_result_t expected[$];
  parse_result_t fresh[$];

  phase_t      ph;
  logic [11:0] fcount;
  logic [43:0] acc;
  logic [11:0] nlen;
  logic [43:0] fsize;
  logic [7:0]  props;
  logic [47:0] position;
  logic [43:0] remaining;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") v = 5'(c - "0");
    if (c >= "A" && c <= "F") v = 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") v = 5'(c - "a" + 10);
    return v;
  endfunction

  task automatic restart();
    ph = PH_SIG;
    fcount = '0;
    acc = '0;
    nlen = '0;
    fsize = '0;
    props = '0;
    position = '0;
    remaining = '0;
  endtask

  task automatic open_field(input phase_t next);
    ph = next;
    fcount = '0;
    acc = '0;
  endtask

  task automatic post(input kind_t k, input logic [7:0] ch, input logic [11:0] len,
                      input logic [43:0] sz, input logic [7:0] pr, input logic [47:0] off);
    parse_result_t r;
    r.kind = k;
    r.char_value = ch;
    r.name_length = len;
    r.entry_size = sz;
    r.property_bits = pr;
    r.data_offset = off;
    r.run_end = 1'b0;
    fresh.insert(fresh.size(), r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [47:0]   here;
    logic [4:0]    nib;
    logic          done_entry;
    logic          failed;
    parse_result_t tail;
    here = position;
    position = here + 1;
    done_entry = 1'b0;
    failed = 1'b0;
    fresh.delete();
    if (ph == PH_DRAIN) begin
      if (last) restart();
    end else if (last && here < MIN_ARCHIVE) begin
      // Too short to be an archive, whatever the byte would otherwise do.
      post(K_EMPTY, 0, 0, 0, 0, 0);
      restart();
    end else begin
      case (ph)
        PH_SIG: begin
          if (fcount > 4 || b != MAGIC[fcount[2:0]]) begin
            post(K_BADSIG, 0, 0, 0, 0, 0);
            failed = 1'b1;
          end else begin
            fcount = fcount + 1;
            if (fcount == 5) open_field(PH_NLEN);
          end
        end
        PH_NLEN, PH_SIZE: begin
          // Padding takes a digit slot but leaves the value alone.
          if (b != CH_PAD) begin
            nib = digit_value(b);
            if (nib > 15) begin
              post(K_BADHEX, 0, 0, 0, 0, 0);
              failed = 1'b1;
            end else begin
              acc = {acc[39:0], nib[3:0]};
            end
          end
          if (!failed) begin
            fcount = fcount + 1;
            if (ph == PH_NLEN && fcount >= 3) begin
              nlen = acc[11:0];
              if (nlen == 0) open_field(PH_SIZE);
              else open_field(PH_NAME);
            end else if (ph == PH_SIZE && fcount >= 11) begin
              fsize = acc;
              props = '0;
              open_field(PH_PROP);
            end
          end
        end
        PH_NAME: begin
          post(K_NAME, b, 0, 0, 0, 0);
          fcount = fcount + 1;
          if (fcount >= nlen) open_field(PH_SIZE);
        end
        PH_PROP: begin
          if (b != CH_ZERO) props[fcount[2:0]] = 1'b1;
          fcount = fcount + 1;
          if (fcount >= 8) open_field(PH_CRC);
        end
        PH_CRC: begin
          if (b != CH_PAD) post(K_CRC, b, 0, 0, 0, 0);
          fcount = fcount + 1;
          if (fcount >= 10) begin
            post(K_REC, 0, nlen, fsize, props, here + 1);
            if (fsize == 0) begin
              done_entry = 1'b1;
            end else begin
              remaining = fsize;
              ph = PH_DATA;
            end
          end
        end
        default: begin
          remaining = remaining - 1;
          if (remaining == 0) done_entry = 1'b1;
        end
      endcase
      if (failed) begin
        if (last) restart();
        else ph = PH_DRAIN;
      end else if (last) begin
        if (done_entry || ph == PH_DATA) post(K_DONE, 0, 0, 0, 0, 0);
        else post(K_TRUNC, 0, 0, 0, 0, 0);
        restart();
      end else if (done_entry) begin
        open_field(PH_NLEN);
      end
    end
    if (fresh.size() > 0) begin
      tail = fresh.pop_back();
      tail.run_end = 1'b1;
      fresh.insert(fresh.size(), tail);
    end
    foreach (fresh[i]) expected.insert(expected.size(), fresh[i]);
  endtask

  task automatic check_result();
    parse_result_t got;
    parse_result_t want;
    got.kind = kind_t'(result_bus.kind);
    got.char_value = result_bus.char_value;
    got.name_length = result_bus.name_length;
    got.entry_size = result_bus.entry_size;
    got.property_bits = result_bus.property_bits;
    got.data_offset = result_bus.data_offset;
    got.run_end = result_bus.run_end;
    if (expected.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: result with nothing expected: kind=%0d char=%h end=%b",
                 $realtime, got.kind, got.char_value, got.run_end);
    end else begin
      want = expected.pop_front();
      if (got.kind !== want.kind || got.char_value !== want.char_value ||
          got.name_length !== want.name_length || got.entry_size !== want.entry_size ||
          got.property_bits !== want.property_bits ||
          got.data_offset !== want.data_offset || got.run_end !== want.run_end) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: expected kind=%0d char=%h len=%h size=%h props=%h off=%h end=%b",
                   $realtime, want.kind, want.char_value, want.name_length,
                   want.entry_size, want.property_bits, want.data_offset, want.run_end);
          $display("%0t: actual   kind=%0d char=%h len=%h size=%h props=%h off=%h end=%b",
                   $realtime, got.kind, got.char_value, got.name_length,
                   got.entry_size, got.property_bits, got.data_offset, got.run_end);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart();
      expected.delete();
      fail_count = 0;
    end else begin
      // A result leaves from a register loaded by its byte, so taking the
      // byte first keeps the queue in order.
      if (byte_bus.valid && byte_bus.ready) parse_byte(byte_bus.data_byte, byte_bus.final_byte);
      if (result_bus.valid && result_bus.ready) check_result();
    end
    backlog = expected.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the archive directory parser: hand-built archives for the
// corner cases, then random archives, mostly well formed with random content
// and some corrupted, cut short or noisy, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench import adp_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned backlog;

  logic [7:0] archive[$];
  bit         calm;

  adp_in_if  byte_bus ();
  adp_out_if result_bus ();

  archive_directory_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (byte_bus),
    .out_stream(result_bus)
  );

  parse_result_check monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_bus  (byte_bus),
    .result_bus(result_bus),
    .fail_count(fail_count),
    .backlog   (backlog)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid <= 1'b1;
    byte_bus.data_byte <= value;
    byte_bus.final_byte <= last;
    do @(posedge clk); while (!byte_bus.ready);
  endtask

  task automatic send_archive();
    foreach (archive[i]) send_byte(archive[i], i == archive.size() - 1);
    archive.delete();
  endtask

  task automatic put_byte(input logic [7:0] value);
    archive.insert(archive.size(), value);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_sig();
    put_byte(8'h25);
    put_byte(8'h42);
    put_byte(8'h41);
    put_byte(8'h54);
    put_byte(8'h25);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'("0" + nib);
    return $urandom_range(0, 1) ? 8'("A" + nib - 10) : 8'("a" + nib - 10);
  endfunction

  // Writes a hex field of fixed width. Pads may stand anywhere, but a zero
  // may only lead, since it would shift the value once a digit is in.
  task automatic put_hex(input logic [43:0] value, input int width);
    int k;
    int placed;
    k = 0;
    placed = 0;
    for (int i = 0; i < width; i++) if (value[4*i +: 4] != 0) k = i + 1;
    for (int slot = 0; slot < width; slot++) begin
      if (k - placed == width - slot || (placed < k && $urandom_range(0, 2) != 0)) begin
        put_byte(hex_char(value[4*(k-1-placed) +: 4]));
        placed++;
      end else if (placed == 0 && $urandom_range(0, 1)) begin
        put_byte(CH_ZERO);
      end else begin
        put_byte(CH_PAD);
      end
    end
  endtask

  task automatic put_entry(input logic [11:0] nlen, input logic [43:0] fsize);
    put_hex(44'(nlen), 3);
    repeat (nlen) put_byte(8'($urandom_range(0, 255)));
    put_hex(fsize, 11);
    for (int i = 0; i < 8; i++)
      put_byte($urandom_range(0, 1) ? CH_ZERO : 8'($urandom_range(0, 255)));
    for (int i = 0; i < 10; i++)
      put_byte($urandom_range(0, 3) == 0 ? CH_PAD : 8'($urandom_range(0, 255)));
    // Large entries are only started; the archive then ends inside the data.
    if (fsize > 16) repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
    else repeat (int'(fsize)) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic build_archive();
    int          entries;
    logic [11:0] nlen;
    logic [43:0] fsize;
    archive.delete();
    put_sig();
    entries = $urandom_range(1, 3);
    for (int e = 0; e < entries; e++) begin
      nlen = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(5, 60)) : 12'($urandom_range(0, 4));
      case ($urandom_range(0, 7))
        0:       fsize = '0;
        1:       fsize = 44'({$urandom, $urandom});
        2:       fsize = '1;
        default: fsize = 44'($urandom_range(1, 6));
      endcase
      put_entry(nlen, fsize);
      if (fsize > 16) break;
    end
  endtask

  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
    end
  end

  initial begin
    int unsigned good_bytes;
    int          pick;
    int          cut;
    int          idx;
    calm = 1'b0;
    rst_n <= 1'b0;
    byte_bus.valid <= 1'b0;
    byte_bus.data_byte <= 8'h00;
    byte_bus.final_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // A lone final byte, and archives ending just below and at the minimum.
    put_byte(8'hFF);
    send_archive();
    put_sig();
    put_str("00");
    send_archive();
    put_sig();
    put_str("000");
    send_archive();
    // Bad signature; the rest is ignored up to the final byte.
    put_byte(8'h25);
    put_byte(8'h42);
    put_byte(8'h00);
    put_str("xyz");
    send_archive();
    // Bad hex in the name length, then in the size.
    put_sig();
    put_str("0G1abc");
    send_archive();
    put_sig();
    put_str("00012&z0000000");
    send_archive();
    // Two entries: a padded one with data, then an empty one whose last CRC
    // character is also the final byte.
    put_sig();
    put_str("&&3");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h51);
    put_str("&&&&&&&&&020a0Z000012&4567&89");
    put_byte(8'h80);
    put_byte(8'h7F);
    put_str("0&00000000000000000000&&&&&&&&&9");
    send_archive();
    // Largest size, data cut short.
    put_sig();
    put_str("001xFFFfffFFFff11111111abcdefghij");
    put_byte(8'h01);
    put_byte(8'hFE);
    put_byte(8'h26);
    send_archive();
    // Header cut short inside the name.
    put_sig();
    put_str("002a");
    send_archive();
    // The byte that ends the data is also the final byte.
    put_sig();
    put_str("00000000000001000000000123456789");
    put_byte(8'hAA);
    send_archive();

    good_bytes = 0;
    while (good_bytes < 130) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      build_archive();
      if (pick == 0) begin
        archive.delete();
        put_sig();
        repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        idx = $urandom_range(0, archive.size() - 1);
        archive[idx] = 8'($urandom_range(0, 255));
      end else if (pick == 2) begin
        cut = $urandom_range(1, archive.size());
        while (archive.size() > cut) void'(archive.pop_back());
      end else begin
        good_bytes += archive.size();
      end
      send_archive();
    end
    calm = 1'b0;
    byte_bus.valid <= 1'b0;

    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("archive_directory_parser_unit: match");
    end else begin
      $display("archive_directory_parser_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("archive_directory_parser_unit: mismatch");
    $finish;
  end

endmodule

// ----- archive_directory_parser_unit.f -----
+incdir+rtl
rtl/adp_pkg.sv
rtl/adp_in_if.sv
rtl/adp_out_if.sv
rtl/adp_parse_core.sv
rtl/adp_result_queue.sv
rtl/archive_directory_parser_unit.sv
tb/parse_result_check.sv
tb/testbench.sv
